>>> rtl/mdlb_pkg.sv
package mdlb_pkg;

  localparam int OFF_W = 32;
  localparam int COST_W = 40;
  localparam int COST_FRAC = 8;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_TOL = 8'd1;

  typedef struct packed {
    logic start;
    logic last;
    logic [OFF_W-1:0] width;
  } cost_req_t;

  typedef struct packed {
    logic done;
    logic [COST_W-1:0] cost;
  } cost_rsp_t;

endpackage

>>> rtl/min_demerit_line_breaker.sv
// minimum-demerit line breaker
// s_axis carries one paragraph: tdata = break_offset (Q16.16), tlast = is_end.
// break items are stored in node memory and give no result; one is taken per
// cycle while no result waits. the end item starts a shortest-path sweep over
// all node pairs. a pair that fits goes through a shared cost unit (bit-serial
// divide), a pair ending the last line costs zero without the divide, and a
// rejected pair skips the cost unit; n nodes give n*(n-1)/2 pairs. then a
// backtrack stacks the line ends, and results are read back in paragraph order.
// m_axis carries tdata = target_width, tuser = status, tlast = last_of_run.
// results wait in an output register while the receiver stalls; the block
// takes no new item until the whole run is delivered.
// cfg writes: index 0 line_width, index 1 fit_tolerance, taken when idle.
// reset empties the node list and clears overflow; node memories are scratch.
module min_demerit_line_breaker #(
  parameter int MAX_BREAKS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // break_offset
  input  logic        s_axis_tlast,  // is_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // target_width
  output logic        m_axis_tuser,  // status
  output logic        m_axis_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mdlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = MAX_BREAKS + 2;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = mdlb_pkg::COST_W;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_IRD   = 10'b0000000010,
    S_JRD   = 10'b0000000100,
    S_JCHK  = 10'b0000001000,
    S_JCOST = 10'b0000010000,
    S_IWR   = 10'b0000100000,
    S_BACK  = 10'b0001000000,
    S_ORD   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_EMPTY = 10'b1000000000
  } st_t;

  st_t st;
  logic [31:0] line_width;
  logic [15:0] fit_tol;
  logic [NW-1:0] node_count;
  logic overflow;

  logic [31:0] off_mem [DEPTH];
  logic [CW:0] cost_mem [DEPTH];  // reachable flag above the cost
  logic [AW-1:0] pred_mem [DEPTH];
  logic [AW-1:0] stack_mem [DEPTH];

  logic [31:0] off_rd;
  logic [CW:0] cost_rd;
  logic [AW-1:0] pred_rd;
  logic [AW-1:0] stack_rd;
  logic [AW-1:0] off_ra, cost_ra, pred_ra, stack_ra;

  logic [NW-1:0] n, i, j, depth, k;
  logic [31:0] off_i, off_j, off_p;
  logic [CW-1:0] cost_j, best;
  logic val_j;
  logic [AW-1:0] bpred, e;
  logic bval;
  logic [31:0] w;
  logic [32:0] limit;
  logic [CW:0] sum;
  logic [2:0] ph;

  mdlb_pkg::cost_req_t creq;
  mdlb_pkg::cost_rsp_t crsp;

  mdlb_cost #(.FRAC_BITS(FRAC_BITS)) u_cost (
    .clk(clk), .rst(rst), .line_width(line_width), .req(creq), .rsp(crsp)
  );

  assign s_axis_tready = (st == S_LOAD) && !m_axis_tvalid;
  assign cfg_ready = (st == S_LOAD);
  assign limit = {1'b0, line_width} + 33'(fit_tol);
  assign w = off_i - off_j;
  assign sum = {1'b0, cost_j} + {1'b0, crsp.cost};

  always_ff @(posedge clk) begin
    off_rd <= off_mem[off_ra];
    cost_rd <= cost_mem[cost_ra];
    pred_rd <= pred_mem[pred_ra];
    stack_rd <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_LOAD;
      line_width <= '0;
      fit_tol <= 16'd1;
      node_count <= NW'(1);
      overflow <= 1'b0;
      m_axis_tvalid <= 1'b0;
      creq <= '0;
    end else begin
      creq.start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mdlb_pkg::REG_LINE_WIDTH) line_width <= cfg_data;
        else if (cfg_index == mdlb_pkg::REG_FIT_TOL) fit_tol <= cfg_data[15:0];
      end
      case (st)
        S_LOAD: begin
          if (s_axis_tvalid && s_axis_tready) begin
            if (!s_axis_tlast) begin
              if (node_count - NW'(1) < NW'(MAX_BREAKS)) begin
                off_mem[node_count[AW-1:0]] <= s_axis_tdata;
                node_count <= node_count + NW'(1);
              end else overflow <= 1'b1;
            end else begin
              node_count <= NW'(1);
              overflow <= 1'b0;
              if (line_width == '0 || node_count <= NW'(1) || overflow) begin
                st <= S_EMPTY;
              end else begin
                off_mem[node_count[AW-1:0]] <= s_axis_tdata;
                cost_mem[0] <= {1'b1, {CW{1'b0}}};
                pred_mem[0] <= '0;
                n <= node_count + NW'(1);
                i <= NW'(1);
                ph <= '0;
                st <= S_IRD;
              end
            end
          end
        end
        S_IRD: begin
          off_ra <= i[AW-1:0];
          ph <= ph + 3'd1;
          if (ph == 3'd0 && i == NW'(1)) off_mem[0] <= '0;
          if (ph == 3'd2) begin
            off_i <= off_rd;
            bval <= 1'b0;
            best <= '0;
            bpred <= '0;
            j <= '0;
            ph <= '0;
            st <= S_JRD;
          end
        end
        S_JRD: begin
          off_ra <= j[AW-1:0];
          cost_ra <= j[AW-1:0];
          ph <= ph + 3'd1;
          if (ph == 3'd2) begin
            off_j <= off_rd;
            cost_j <= cost_rd[CW-1:0];
            val_j <= cost_rd[CW];
            ph <= '0;
            st <= S_JCHK;
          end
        end
        S_JCHK: begin
          if (!val_j || off_i < off_j || {1'b0, w} > limit) begin
            if (j + NW'(1) == i) st <= S_IWR;
            else begin
              j <= j + NW'(1);
              st <= S_JRD;
            end
          end else begin
            creq.start <= 1'b1;
            creq.last <= (i == n - NW'(1));
            creq.width <= w;
            st <= S_JCOST;
          end
        end
        S_JCOST: begin
          if (crsp.done) begin
            if (!bval || (sum > {1'b0, mdlb_pkg::COST_MAX} ? mdlb_pkg::COST_MAX
                          : sum[CW-1:0]) < best) begin
              best <= sum > {1'b0, mdlb_pkg::COST_MAX} ? mdlb_pkg::COST_MAX : sum[CW-1:0];
              bpred <= j[AW-1:0];
              bval <= 1'b1;
            end
            if (j + NW'(1) == i) st <= S_IWR;
            else begin
              j <= j + NW'(1);
              st <= S_JRD;
            end
          end
        end
        S_IWR: begin
          cost_mem[i[AW-1:0]] <= {bval, best};
          pred_mem[i[AW-1:0]] <= bpred;
          if (i + NW'(1) == n) begin
            if (!bval) st <= S_EMPTY;
            else begin
              e <= i[AW-1:0];
              depth <= '0;
              ph <= '0;
              st <= S_BACK;
            end
          end else begin
            i <= i + NW'(1);
            ph <= '0;
            st <= S_IRD;
          end
        end
        S_BACK: begin
          pred_ra <= e;
          ph <= ph + 3'd1;
          if (ph == 3'd2) begin
            stack_mem[depth[AW-1:0]] <= e;
            depth <= depth + NW'(1);
            e <= pred_rd;
            ph <= '0;
            if (pred_rd == '0) begin
              if (depth == '0) st <= S_EMPTY;
              else begin
                k <= depth;
                st <= S_ORD;
              end
            end
          end
        end
        S_ORD: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd0: stack_ra <= k[AW-1:0];
            3'd2: begin
              pred_ra <= stack_rd;
              off_ra <= stack_rd;
            end
            3'd4: begin
              off_i <= off_rd;
              off_ra <= pred_rd;
            end
            3'd6: begin
              off_p <= off_rd;
              ph <= '0;
              st <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= off_i - off_p;
            m_axis_tuser <= 1'b0;
            m_axis_tlast <= (k == NW'(1));
            if (k == NW'(1)) st <= S_LOAD;
            else begin
              k <= k - NW'(1);
              st <= S_ORD;
            end
          end
        end
        S_EMPTY: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= '0;
            m_axis_tuser <= 1'b1;
            m_axis_tlast <= 1'b1;
            st <= S_LOAD;
          end
        end
        default: st <= S_LOAD;
      endcase
    end
  end

endmodule

>>> rtl/mdlb_cost.sv
module mdlb_cost #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mdlb_pkg::OFF_W-1:0]    line_width,
  input  mdlb_pkg::cost_req_t           req,
  output mdlb_pkg::cost_rsp_t           rsp
);

  localparam int DW = mdlb_pkg::OFF_W + FRAC_BITS;
  localparam int SW = FRAC_BITS + 5;
  localparam int S2W = FRAC_BITS + 9;
  localparam int S3W = FRAC_BITS + 13;
  localparam int DMW = FRAC_BITS + 20;
  localparam int D8W = DMW - (FRAC_BITS - mdlb_pkg::COST_FRAC);
  localparam int SQW = 2 * D8W;
  localparam int SHW = SQW - mdlb_pkg::COST_FRAC;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV   = 8'b00000010,
    S_CLAMP = 8'b00000100,
    S_SQ    = 8'b00001000,
    S_CUBE  = 8'b00010000,
    S_DEM   = 8'b00100000,
    S_SQR   = 8'b01000000,
    S_SAT   = 8'b10000000
  } st_t;

  st_t st;
  logic [DW-1:0] num;
  logic [mdlb_pkg::OFF_W-1:0] rem;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic over;
  logic [SW-1:0] s;
  logic [S2W-1:0] s2;
  logic [S3W-1:0] s3;
  logic [DMW-1:0] dm;
  logic [SQW-1:0] sq;
  logic [mdlb_pkg::OFF_W:0] rem_sh;
  logic [mdlb_pkg::OFF_W-1:0] diff;
  logic [2*SW-1:0] ss;
  logic [S2W+SW-1:0] s2s;
  logic [DMW-1:0] bad;
  logic [DMW-1:0] ten;
  logic [DMW-1:0] dm_next;
  logic [D8W-1:0] d8;
  logic [SHW-1:0] sq_sh;

  assign diff = (req.width > line_width) ? req.width - line_width : line_width - req.width;
  assign rem_sh = {rem, num[DW-1]};
  assign ss = (2*SW)'(s) * (2*SW)'(s);
  assign s2s = (S2W+SW)'(s2) * (S2W+SW)'(s);
  assign ten = DMW'(10) << FRAC_BITS;
  assign bad = DMW'(s3) * DMW'(100);
  always_comb begin
    if (!over) dm_next = ten + bad;
    else if (bad <= ten) dm_next = ten - bad;
    else dm_next = bad - ten;
  end
  assign d8 = D8W'(dm >> (FRAC_BITS - mdlb_pkg::COST_FRAC));
  assign sq_sh = sq[SQW-1:mdlb_pkg::COST_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (req.start) begin
            if (req.last) begin
              rsp.cost <= '0;
              rsp.done <= 1'b1;
            end else begin
              over <= req.width > line_width;
              num <= DW'(diff) << FRAC_BITS;
              rem <= '0;
              quo <= '0;
              cnt <= CW'(DW);
              st <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, line_width}) begin
            rem <= mdlb_pkg::OFF_W'(rem_sh - {1'b0, line_width});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[mdlb_pkg::OFF_W-1:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= S_CLAMP;
        end
        S_CLAMP: begin
          if (quo > (DW'(1) << (FRAC_BITS + 4))) s <= SW'(1) << (FRAC_BITS + 4);
          else s <= quo[SW-1:0];
          st <= S_SQ;
        end
        S_SQ: begin
          s2 <= S2W'(ss >> FRAC_BITS);
          st <= S_CUBE;
        end
        S_CUBE: begin
          s3 <= S3W'(s2s >> FRAC_BITS);
          st <= S_DEM;
        end
        S_DEM: begin
          dm <= dm_next;
          st <= S_SQR;
        end
        S_SQR: begin
          sq <= SQW'(d8) * SQW'(d8);
          st <= S_SAT;
        end
        S_SAT: begin
          rsp.cost <= (sq_sh > SHW'(mdlb_pkg::COST_MAX)) ? mdlb_pkg::COST_MAX
                      : sq_sh[mdlb_pkg::COST_W-1:0];
          rsp.done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mdlb_checker.sv
module mdlb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 32'd0)
    else $error("empty result malformed");

  a_noin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");

endmodule

bind min_demerit_line_breaker mdlb_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);

>>> sim/min_demerit_line_breaker_test.sv
module min_demerit_line_breaker_test;

  localparam int MAX_BREAKS = 64;
  localparam int FRAC_BITS = 16;
  localparam int NODE_DEPTH = MAX_BREAKS + 2;
  localparam logic [63:0] COST_CAP = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] width;
    logic        status;
    logic        last;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // break_offset
  logic s_axis_tlast = 1'b0;       // is_end
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // target_width
  logic m_axis_tuser;              // status
  logic m_axis_tlast;              // last_of_run
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mdlb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  min_demerit_line_breaker #(.MAX_BREAKS(MAX_BREAKS), .FRAC_BITS(FRAC_BITS)) u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of block state
  logic [31:0] measure_q = 32'd0;
  logic [15:0] tolerance_q = 16'd1;
  logic [31:0] offsets_q [NODE_DEPTH];
  logic [63:0] path_cost [NODE_DEPTH];
  logic        reached [NODE_DEPTH];
  int          pred_node [NODE_DEPTH];
  int          line_ends [NODE_DEPTH];
  int          nodes_q = 1;
  logic        overflow_q = 1'b0;

  line_result_t expected_lines[$];
  int errors = 0;
  int checked = 0;
  int paragraphs = 0;
  int send_idle = 0;
  int recv_stall = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] demerit_cost(logic [31:0] w);
    logic [63:0] meas, diff, s, s2, s3, bad, ten, dm, d8, sq;
    logic over;
    meas = {32'd0, measure_q};
    over = {32'd0, w} > meas;
    diff = over ? {32'd0, w} - meas : meas - {32'd0, w};
    s = (diff << FRAC_BITS) / meas;
    if (s > (64'd1 << (FRAC_BITS + 4))) s = 64'd1 << (FRAC_BITS + 4);
    s2 = (s * s) >> FRAC_BITS;
    s3 = (s2 * s) >> FRAC_BITS;
    bad = 64'd100 * s3;
    ten = 64'd10 << FRAC_BITS;
    if (!over) dm = ten + bad;
    else if (bad <= ten) dm = ten - bad;
    else dm = bad - ten;
    d8 = dm >> (FRAC_BITS - mdlb_pkg::COST_FRAC);
    sq = (d8 * d8) >> mdlb_pkg::COST_FRAC;
    return sq > COST_CAP ? COST_CAP : sq;
  endfunction

  task automatic push_empty();
    line_result_t r;
    r.width = '0; r.status = 1'b1; r.last = 1'b1;
    expected_lines.insert(expected_lines.size(), r);
  endtask

  task automatic break_paragraph(logic [31:0] end_width);
    int n, depth, node;
    logic [63:0] limit, w, c, sum;
    line_result_t r;
    if (measure_q == 0 || nodes_q <= 1 || overflow_q) begin
      push_empty();
      return;
    end
    offsets_q[nodes_q] = end_width;
    n = nodes_q + 1;
    limit = {32'd0, measure_q} + {48'd0, tolerance_q};
    path_cost[0] = 0; reached[0] = 1'b1; pred_node[0] = 0;
    for (int i = 1; i < n; i++) begin
      reached[i] = 1'b0; path_cost[i] = 0; pred_node[i] = 0;
      for (int j = 0; j < i; j++) begin
        if (!reached[j] || offsets_q[i] < offsets_q[j]) continue;
        w = {32'd0, offsets_q[i]} - {32'd0, offsets_q[j]};
        if (w > limit) continue;
        c = (i == n - 1) ? 64'd0 : demerit_cost(w[31:0]);
        sum = path_cost[j] + c;
        if (sum > COST_CAP) sum = COST_CAP;
        if (!reached[i] || sum < path_cost[i]) begin
          path_cost[i] = sum; pred_node[i] = j; reached[i] = 1'b1;
        end
      end
    end
    if (!reached[n-1]) begin
      push_empty();
      return;
    end
    depth = 0;
    node = n - 1;
    while (node > 0 && depth < NODE_DEPTH) begin
      line_ends[depth++] = node;
      node = pred_node[node];
    end
    if (depth <= 1) begin
      push_empty();
      return;
    end
    for (int j = depth; j > 1; j--) begin
      node = line_ends[j-1];
      r.width = offsets_q[node] - offsets_q[pred_node[node]];
      r.status = 1'b0;
      r.last = (j == 2);
      expected_lines.insert(expected_lines.size(), r);
    end
  endtask

  task automatic track_item(logic [31:0] off, logic is_end);
    offsets_q[0] = 0;
    if (!is_end) begin
      if (nodes_q - 1 < MAX_BREAKS) begin
        offsets_q[nodes_q] = off;
        nodes_q++;
      end else begin
        overflow_q = 1'b1;
      end
    end else begin
      break_paragraph(off);
      nodes_q = 1;
      overflow_q = 1'b0;
      paragraphs++;
    end
  endtask

  // called and returns at a falling edge
  task automatic send_item(logic [31:0] off, logic is_end);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = off;
    s_axis_tlast = is_end;
    do @(posedge clk); while (!s_axis_tready);
    track_item(off, is_end);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [mdlb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mdlb_pkg::REG_LINE_WIDTH) measure_q = value;
    else if (idx == mdlb_pkg::REG_FIT_TOL) tolerance_q = value[15:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_lines.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      checked++;
      if (expected_lines.size() == 0) begin
        report("unexpected transaction", m_axis_tdata, 0);
      end else begin
        want = expected_lines.pop_front();
        if (m_axis_tdata !== want.width) report("target_width", m_axis_tdata, want.width);
        if (m_axis_tuser !== want.status) report("status", m_axis_tuser, want.status);
        if (m_axis_tlast !== want.last) report("last_of_run", m_axis_tlast, want.last);
      end
    end
  end

  task automatic test_reset_defaults();
    send_item(32'd0, 1'b1);
    send_item(32'h0010_0000, 1'b0);
    send_item(32'h0020_0000, 1'b1);
    drain();
  endtask

  task automatic test_directed();
    write_reg(mdlb_pkg::REG_LINE_WIDTH, 32'd100 << 16);
    write_reg(mdlb_pkg::REG_FIT_TOL, 32'h0000_FFFF);
    foreach (offsets_q[i]) if (i >= 1 && i <= 5) send_item((30 * i) << 16, 1'b0);
    send_item(32'd200 << 16, 1'b1);
    send_item(32'd50 << 16, 1'b0);
    send_item(32'd50 << 16, 1'b1);
    send_item(32'd0, 1'b1);
    send_item(32'd80 << 16, 1'b0);
    send_item(32'd40 << 16, 1'b0);
    send_item(32'd160 << 16, 1'b1);
    send_item(32'd300 << 16, 1'b0);
    send_item(32'd400 << 16, 1'b1);
    send_item(32'd60 << 16, 1'b0);
    send_item((32'd160 << 16) + 32'hFFFF, 1'b1);
    drain();
    write_reg(mdlb_pkg::REG_LINE_WIDTH, 32'hFFFF_FFFF);
    write_reg(mdlb_pkg::REG_FIT_TOL, 32'd0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    drain();
    write_reg(mdlb_pkg::REG_LINE_WIDTH, 32'd1);
    write_reg(mdlb_pkg::REG_FIT_TOL, 32'd0);
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd3, 1'b1);
    drain();
  endtask

  task automatic test_capacity();
    write_reg(mdlb_pkg::REG_LINE_WIDTH, 32'd10 << 16);
    write_reg(mdlb_pkg::REG_FIT_TOL, 32'd1);
    for (int i = 1; i <= MAX_BREAKS + 1; i++) send_item((3 * i) << 16, 1'b0);
    send_item(32'd200 << 16, 1'b1);
    for (int i = 1; i <= MAX_BREAKS; i++) send_item((3 * i) << 16, 1'b0);
    send_item(32'd195 << 16, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int items);
    logic [31:0] lw, pos;
    int sent, nb;
    send_idle = idle;
    recv_stall = stall;
    lw = $urandom_range(32'd200 << 16, 32'd1 << 18);
    write_reg(mdlb_pkg::REG_LINE_WIDTH, lw);
    write_reg(mdlb_pkg::REG_FIT_TOL, $urandom_range(16'hFFFF, 0));
    sent = 0;
    while (sent < items) begin
      nb = $urandom_range(5, 1);
      pos = 0;
      for (int k = 0; k < nb; k++) begin
        if ($urandom_range(9) == 0) pos = $urandom;
        else pos = pos + $urandom_range(lw + tolerance_q, lw / 4);
        send_item(pos, 1'b0);
      end
      if ($urandom_range(9) == 0) send_item($urandom, 1'b1);
      else send_item(pos + $urandom_range(lw, 1), 1'b1);
      sent += nb + 1;
    end
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_directed();
    test_capacity();
    test_random_phase(0, 0, 6);
    test_random_phase(78, 0, 6);
    test_random_phase(0, 78, 6);
    test_random_phase(14, 14, 6);
    $display("run covered %0d paragraphs and %0d result transactions", paragraphs, checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end
endmodule

>>> sim.f
rtl/mdlb_pkg.sv
rtl/mdlb_cost.sv
rtl/min_demerit_line_breaker.sv
rtl/mdlb_checker.sv
sim/min_demerit_line_breaker_test.sv
